// ----- rtl/core/epqr_pkg.sv -----
// Shared types and constants for the entropy pool generator.
// Used by epqr_mix and the top level; depends on nothing else.
package epqr_pkg;

    localparam int POOL_WORDS_DEF = 16;
    localparam int MIX_COUNT      = 16;

    localparam logic [63:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2     = 64'h94d049bb133111eb;
    localparam logic [63:0] SEED_CONST = 64'h00000000deadbeef;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_SEED,
        KIND_DRAW,
        KIND_RANGE
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS,
        ST_ABS_WAIT,
        ST_SEED_RD,
        ST_SEED_GO,
        ST_SEED_WAIT,
        ST_QR,
        ST_FIN,
        ST_RANGE,
        ST_DIV,
        ST_ADDLO,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mix_stat;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [1:0] sel);
        logic [31:0] r;
        case (sel)
            2'd0:    r = {v[15:0], v[31:16]};
            2'd1:    r = {v[19:0], v[31:20]};
            2'd2:    r = {v[23:0], v[31:24]};
            default: r = {v[24:0], v[31:25]};
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/epqr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module epqr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/epqr_mix.sv -----
// Iterative 64-bit splitmix finalizer: one 16x64 partial product per cycle during each multiply pass.
// Depends on epqr_pkg.
module epqr_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_x,
    output epqr_pkg::t_mix_stat o_stat,
    output logic [63:0]         o_y
);
    import epqr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_ph;
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [63:0] r_y;

    logic [1:0]  k;
    logic [15:0] chunk;
    logic [63:0] cst;
    logic [79:0] prod;
    logic [63:0] part;

    always_comb begin
        k = (r_ph < 4'd4) ? r_ph[1:0] : (r_ph[1:0] - 2'd1);
        case (k)
            2'd0:    chunk = r_x[15:0];
            2'd1:    chunk = r_x[31:16];
            2'd2:    chunk = r_x[47:32];
            default: chunk = r_x[63:48];
        endcase
        cst  = (r_ph < 4'd4) ? MIX_C1 : MIX_C2;
        prod = chunk * cst;
        part = prod[63:0] << {k, 4'b0000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= '0;
            end else if (r_busy) begin
                r_ph <= r_ph + 4'd1;
                if (r_ph == 4'd9) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x ^ (i_x >> 30);
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_ph == 4'd4) begin
                r_x   <= r_acc ^ (r_acc >> 27);
                r_acc <= '0;
            end else if (r_ph == 4'd9) begin
                r_y <= r_acc ^ (r_acc >> 31);
            end else begin
                r_acc <= r_acc + part;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_y         = r_y;
endmodule

// ----- rtl/core/entropy_pool_quarter_round_rng.sv -----
// Top level of the entropy pool generator with quarter-round output stage.
// Depends on epqr_pkg, epqr_ram and epqr_mix.
//
// Input channel: i_in_valid with o_in_stall; an item (kind, value, stamp,
// bounds) is taken when valid is high and stall is low. Output channel:
// o_out_valid with i_out_stall carries o_random_value for draw items only.
// Add-entropy and seed items produce nothing on the output.
// The shared mix unit serves both pool absorbs and seeding mixes. After it is
// accepted, an add-entropy item holds o_in_stall high for one absorb and a seed
// for three absorbs and sixteen mixes. A draw runs sixteen quarter-round steps,
// one per cycle, then a finish step and an output step, and an unseeded block
// runs the full seed first. A range draw adds a bit-serial remainder over all
// 64 dividend bits and an add of the low bound, or only the add when the span
// is the full 2^64.
// One item is in work at a time and o_in_stall stays high until it is finished.
// The result sits in an output register; the next item is accepted while it
// waits, and a finished result waits in place while the receiver stalls.
// Reset clears the pool valid bits, index, mixing words, seeded flag and
// pool_tag; pool entries read as zero until written.
module entropy_pool_quarter_round_rng #(
    parameter int POOL_WORDS = epqr_pkg::POOL_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pool_tag_we,
    input  logic [63:0] i_pool_tag,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_value,
    input  logic [63:0] i_stamp,
    input  logic [63:0] i_low_bound,
    input  logic [63:0] i_high_bound,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_random_value
);
    import epqr_pkg::*;

    localparam int IW = $clog2(POOL_WORDS);

    t_state r_state, n_state;
    t_kind  r_kind;
    logic [63:0] r_tag, r_value, r_stamp, r_lo, r_hi;
    logic [IW-1:0] r_idx;
    logic [POOL_WORDS-1:0] r_valid;
    logic [1:0]  r_abs;
    logic [3:0]  r_cnt;
    logic [3:0]  r_qc;
    logic [5:0]  r_dc;
    logic        r_seeded;
    logic [31:0] r_mw [MIX_COUNT];
    logic [63:0] r_dq, r_span, r_rem, r_res;
    logic        r_out_valid;
    logic [63:0] r_out;

    logic        accept, out_load;
    logic        mix_start;
    logic [63:0] mix_x, mix_y;
    t_mix_stat   mix_stat;
    logic        ram_we;
    logic [IW-1:0] ram_raddr;
    logic [63:0] ram_rdata, ram_wdata, old_word, seed_word;
    logic        even;
    logic [31:0] qsum, qrot;
    logic [64:0] rem_sh;
    logic [63:0] rem_nx;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    epqr_ram #(.WIDTH(64), .DEPTH(POOL_WORDS)) u_pool (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    epqr_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mix_start),
        .i_x     (mix_x),
        .o_stat  (mix_stat),
        .o_y     (mix_y)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((t_kind'(i_kind) == KIND_DRAW || t_kind'(i_kind) == KIND_RANGE)
                        && r_seeded) begin
                        n_state = ST_QR;
                    end else begin
                        n_state = ST_ABS;
                    end
                end
            end
            ST_ABS: n_state = ST_ABS_WAIT;
            ST_ABS_WAIT: begin
                if (mix_stat.done) begin
                    if (r_kind == KIND_ADD) begin
                        n_state = ST_IDLE;
                    end else if (r_abs == 2'd2) begin
                        n_state = ST_SEED_RD;
                    end else begin
                        n_state = ST_ABS;
                    end
                end
            end
            ST_SEED_RD: n_state = ST_SEED_GO;
            ST_SEED_GO: n_state = ST_SEED_WAIT;
            ST_SEED_WAIT: begin
                if (mix_stat.done) begin
                    if (r_cnt != 4'd15) begin
                        n_state = ST_SEED_RD;
                    end else if (r_kind == KIND_SEED) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_QR;
                    end
                end
            end
            ST_QR:    if (r_qc == 4'd15) n_state = ST_FIN;
            ST_FIN:   n_state = (r_kind == KIND_RANGE) ? ST_RANGE : ST_OUT;
            ST_RANGE: n_state = (r_span == '0) ? ST_ADDLO : ST_DIV;
            ST_DIV:   if (r_dc == 6'd63) n_state = ST_ADDLO;
            ST_ADDLO: n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs and datapath selects.
    always_comb begin
        old_word  = r_valid[r_idx] ? ram_rdata : '0;
        seed_word = r_valid[IW'(r_cnt)] ? ram_rdata : '0;
        ram_raddr = r_idx;
        mix_start = 1'b0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        mix_x     = seed_word ^ r_stamp;
        case (r_state)
            ST_ABS: begin
                mix_start = 1'b1;
                if (r_kind == KIND_ADD) begin
                    mix_x = r_value ^ r_stamp;
                end else begin
                    case (r_abs)
                        2'd0:    mix_x = '0;
                        2'd1:    mix_x = r_tag ^ r_stamp;
                        default: mix_x = SEED_CONST;
                    endcase
                end
            end
            ST_ABS_WAIT: ram_we = mix_stat.done;
            ST_SEED_RD:  ram_raddr = IW'(r_cnt);
            ST_SEED_GO: begin
                ram_raddr = IW'(r_cnt);
                mix_start = 1'b1;
            end
            ST_OUT:  out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
        ram_wdata = old_word ^ mix_y;

        even = !r_qc[0];
        qsum = even ? (r_mw[0] + r_mw[1]) : (r_mw[2] + r_mw[3]);
        qrot = rotl32((even ? r_mw[3] : r_mw[1]) ^ qsum, r_qc[1:0]);

        rem_sh = {r_rem, r_dq[63]};
        rem_nx = (rem_sh >= {1'b0, r_span}) ? 64'(rem_sh - {1'b0, r_span}) : rem_sh[63:0];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tag       <= '0;
            r_idx       <= '0;
            r_valid     <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < MIX_COUNT; j++) begin
                r_mw[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_pool_tag_we) begin
                r_tag <= i_pool_tag;
            end
            if (ram_we) begin
                r_valid[r_idx] <= 1'b1;
                r_idx <= (r_idx == IW'(POOL_WORDS - 1)) ? '0 : r_idx + 1'b1;
            end
            if (r_state == ST_SEED_WAIT && mix_stat.done) begin
                for (int j = 0; j < MIX_COUNT - 1; j++) begin
                    r_mw[j] <= r_mw[j+1];
                end
                r_mw[MIX_COUNT-1] <= mix_y[31:0];
                if (r_cnt == 4'd15) begin
                    r_seeded <= 1'b1;
                end
            end
            if (r_state == ST_QR) begin
                if (r_qc[1:0] == 2'd3) begin
                    // Last step of a group: rotate the next group into place.
                    for (int j = 0; j < MIX_COUNT - 4; j++) begin
                        r_mw[j] <= r_mw[j+4];
                    end
                    r_mw[12] <= r_mw[0];
                    r_mw[13] <= qrot;
                    r_mw[14] <= qsum;
                    r_mw[15] <= r_mw[3];
                end else if (even) begin
                    r_mw[0] <= qsum;
                    r_mw[3] <= qrot;
                end else begin
                    r_mw[2] <= qsum;
                    r_mw[1] <= qrot;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= t_kind'(i_kind);
            r_value <= i_value;
            r_stamp <= i_stamp;
            r_lo    <= i_low_bound;
            r_hi    <= i_high_bound;
            r_abs   <= '0;
            r_cnt   <= '0;
            r_qc    <= '0;
        end
        if (r_state == ST_ABS_WAIT && mix_stat.done) begin
            r_abs <= r_abs + 2'd1;
        end
        if (r_state == ST_SEED_WAIT && mix_stat.done) begin
            r_cnt <= r_cnt + 4'd1;
        end
        if (r_state == ST_QR) begin
            r_qc <= r_qc + 4'd1;
        end
        case (r_state)
            ST_FIN: begin
                r_dq   <= {r_mw[0], r_mw[1]};
                r_res  <= {r_mw[0], r_mw[1]};
                r_span <= r_hi - r_lo + 64'd1;
                r_rem  <= '0;
                r_dc   <= '0;
            end
            ST_RANGE: begin
                if (r_span == '0) begin
                    r_rem <= r_dq;
                end
            end
            ST_DIV: begin
                r_rem <= rem_nx;
                r_dq  <= {r_dq[62:0], 1'b0};
                r_dc  <= r_dc + 6'd1;
            end
            ST_ADDLO: r_res <= r_lo + r_rem;
            default: ;
        endcase
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out;

`ifndef ASSERT_OFF
    a_seeded_sticks: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && $past(r_seeded)) |-> r_seeded)
        else $error("seeded flag cleared outside reset");

    a_qr_needs_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QR) |-> r_seeded)
        else $error("quarter rounds started on an unseeded pool");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(r_idx) < POOL_WORDS))
        else $error("pool write beyond its depth");

    a_mix_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_start |-> !mix_stat.busy)
        else $error("mix unit started while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("pending result overwritten");
`endif
endmodule
